/* rtl/tlbt_pkg.sv */
// shared types, constants and set index function for the tlb translate core
package tlbt_pkg;

    localparam int WAYS    = 4;
    localparam int SETS    = 16;
    localparam int ENTRIES = WAYS * SETS;
    localparam int WAY_W   = $clog2(WAYS);
    localparam int SET_W   = $clog2(SETS);
    localparam int SLOT_W  = $clog2(ENTRIES);
    localparam int ENTRY_W = 64;

    localparam logic [19:0] VPN_MASK  = 20'hFFFFF;
    localparam int          FLAG_VLD  = 0;
    localparam int          FLAG_WR   = 1;
    localparam int          FLAG_KERN = 2;
    localparam int          FLAG_UNC  = 3;
    localparam int          FLAG_GLB  = 4;

    typedef enum logic [1:0] {
        OP_TRANSLATE = 2'd0,
        OP_WRITE     = 2'd1,
        OP_PROBE     = 2'd2,
        OP_READ      = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MISS    = 2'd1,
        ST_FAULT_R = 2'd2,
        ST_FAULT_W = 2'd3
    } t_status;

    typedef struct packed {
        t_op                op;
        logic [31:0]        virt_addr;
        logic [11:0]        asid;
        logic               is_write;
        logic               user_mode;
        logic [SLOT_W-1:0]  entry_index;
        logic [31:0]        entry_key;
        logic [31:0]        entry_flags;
    } t_item;

    typedef struct packed {
        t_status            status;
        logic [31:0]        phys_addr;
        logic               uncached;
        logic [31:0]        miss_key;
        logic [11:0]        dir_offset;
        logic [SLOT_W-1:0]  slot_out;
        logic               probe_hit;
        logic [31:0]        read_hi;
        logic [31:0]        read_lo;
    } t_result;

    // low bits of the vpn pick the set, vpn bit 19 picks the kernel half
    function automatic logic [SET_W-1:0] set_of(input logic [19:0] vpn);
        set_of = {vpn[19], vpn[SET_W-2:0]};
    endfunction

endpackage

/* rtl/set_assoc_tlb_translate_core.sv */
// top level of the set-associative tlb: set memory, compare stage and result register
//
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+------------------------------------------
//  request  | i_in_valid   | o_in_stall   | i_op .. i_entry_flags
//  result   | o_out_valid  | i_out_stall  | o_status .. o_read_lo
//
//  each word has its set read from the memory, then goes through the way compare into the
//  result register; a new word is taken once the compare stage empties
//  a finished result may wait in the output register while the next word is read
//  entry writes land in the memory when the word leaves the compare stage
//  reset clears the per-entry valid bits directly; there is no clearing pass
module set_assoc_tlb_translate_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_op,
    input  logic [31:0]                   i_virt_addr,
    input  logic [11:0]                   i_asid,
    input  logic                          i_is_write,
    input  logic                          i_user_mode,
    input  logic [tlbt_pkg::SLOT_W-1:0]   i_entry_index,
    input  logic [31:0]                   i_entry_key,
    input  logic [31:0]                   i_entry_flags,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_status,
    output logic [31:0]                   o_phys_addr,
    output logic                          o_uncached,
    output logic [31:0]                   o_miss_key,
    output logic [11:0]                   o_dir_offset,
    output logic [tlbt_pkg::SLOT_W-1:0]   o_slot_out,
    output logic                          o_probe_hit,
    output logic [31:0]                   o_read_hi,
    output logic [31:0]                   o_read_lo
);

    tlbt_pkg::t_item                              r_item;
    logic                                         r_busy;
    logic                                         n_busy;
    logic                                         r_out_vld;
    logic                                         n_out_vld;
    tlbt_pkg::t_result                            r_res;
    logic [tlbt_pkg::WAY_W-1:0]                   r_refill_cnt;
    logic [tlbt_pkg::WAY_W-1:0]                   n_refill_cnt;
    logic [tlbt_pkg::ENTRIES-1:0]                 r_entry_vld;
    logic [tlbt_pkg::WAYS-1:0]                    r_row_vld;

    logic                                         w_acc;
    logic                                         w_adv;
    logic                                         w_wr;
    tlbt_pkg::t_op                                w_in_op;
    logic [tlbt_pkg::SET_W-1:0]                   w_rd_addr;
    logic [tlbt_pkg::WAYS*tlbt_pkg::ENTRY_W-1:0]  w_row;
    logic [tlbt_pkg::WAYS-1:0]                    w_wr_lane;
    logic [31:0]                                  w_wr_key;
    tlbt_pkg::t_result                            w_res;

    assign w_in_op = tlbt_pkg::t_op'(i_op);
    assign w_acc   = i_in_valid && !r_busy;
    assign w_adv   = r_busy && (!r_out_vld || !i_out_stall);
    assign w_wr    = w_adv && (r_item.op == tlbt_pkg::OP_WRITE);

    always_comb begin
        case (w_in_op)
            tlbt_pkg::OP_TRANSLATE: w_rd_addr = tlbt_pkg::set_of(i_virt_addr[31:12]);
            tlbt_pkg::OP_PROBE:     w_rd_addr = tlbt_pkg::set_of(i_entry_key[19:0]);
            default:                w_rd_addr = i_entry_index[tlbt_pkg::SLOT_W-1:tlbt_pkg::WAY_W];
        endcase
    end

    // global entries keep only the vpn in the stored key
    assign w_wr_key  = r_item.entry_flags[tlbt_pkg::FLAG_GLB]
                     ? {12'd0, r_item.entry_key[19:0] & tlbt_pkg::VPN_MASK}
                     : r_item.entry_key;
    assign w_wr_lane = {{(tlbt_pkg::WAYS-1){1'b0}}, 1'b1}
                       << r_item.entry_index[tlbt_pkg::WAY_W-1:0];

    tlbt_ram #(
        .DEPTH  (tlbt_pkg::SETS),
        .LANES  (tlbt_pkg::WAYS),
        .LANE_W (tlbt_pkg::ENTRY_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr),
        .i_wr_addr (r_item.entry_index[tlbt_pkg::SLOT_W-1:tlbt_pkg::WAY_W]),
        .i_wr_lane (w_wr_lane),
        .i_wr_data ({w_wr_key, r_item.entry_flags}),
        .i_rd_en   (w_acc),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_row)
    );

    tlbt_lookup u_lookup (
        .i_item       (r_item),
        .i_row        (w_row),
        .i_row_vld    (r_row_vld),
        .i_refill_cnt (r_refill_cnt),
        .o_res        (w_res)
    );

    always_comb begin
        n_busy       = r_busy;
        n_out_vld    = r_out_vld;
        n_refill_cnt = r_refill_cnt;
        if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end
        if (w_adv) begin
            n_busy    = 1'b0;
            n_out_vld = 1'b1;
        end
        if (w_acc) begin
            n_busy = 1'b1;
        end
        if (w_wr) begin
            if (r_refill_cnt == tlbt_pkg::WAY_W'(tlbt_pkg::WAYS - 1)) begin
                n_refill_cnt = '0;
            end else begin
                n_refill_cnt = r_refill_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_out_vld    <= 1'b0;
            r_refill_cnt <= '0;
            r_entry_vld  <= '0;
        end else begin
            r_busy       <= n_busy;
            r_out_vld    <= n_out_vld;
            r_refill_cnt <= n_refill_cnt;
            if (w_wr) begin
                r_entry_vld[r_item.entry_index] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_item.op          <= w_in_op;
            r_item.virt_addr   <= i_virt_addr;
            r_item.asid        <= i_asid;
            r_item.is_write    <= i_is_write;
            r_item.user_mode   <= i_user_mode;
            r_item.entry_index <= i_entry_index;
            r_item.entry_key   <= i_entry_key;
            r_item.entry_flags <= i_entry_flags;
            r_row_vld          <= r_entry_vld[{w_rd_addr, {tlbt_pkg::WAY_W{1'b0}}}
                                              +: tlbt_pkg::WAYS];
        end
        if (w_adv) begin
            r_res <= w_res;
        end
    end

    assign o_in_stall   = r_busy;
    assign o_out_valid  = r_out_vld;
    assign o_status     = r_res.status;
    assign o_phys_addr  = r_res.phys_addr;
    assign o_uncached   = r_res.uncached;
    assign o_miss_key   = r_res.miss_key;
    assign o_dir_offset = r_res.dir_offset;
    assign o_slot_out   = r_res.slot_out;
    assign o_probe_hit  = r_res.probe_hit;
    assign o_read_hi    = r_res.read_hi;
    assign o_read_lo    = r_res.read_lo;

    a_acc_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r_busy)
        else $error("accepted word did not enter the compare stage");

    a_cnt_only_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_refill_cnt) |-> $past(w_wr))
        else $error("refill counter moved without an entry write");

    a_result_from_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_busy))
        else $error("result appeared with an empty compare stage");

    a_probe_hit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_res.probe_hit) |-> (r_res.status == tlbt_pkg::ST_OK))
        else $error("probe hit carries a non-ok status");

    a_miss_no_paddr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_res.status == tlbt_pkg::ST_MISS)) |-> (r_res.phys_addr == '0))
        else $error("miss result carries a physical address");

endmodule

/* rtl/tlbt_ram.sv */
// one-port-write one-port-read synchronous ram with per-lane write enables
module tlbt_ram #(
    parameter int DEPTH  = 16,
    parameter int LANES  = 4,
    parameter int LANE_W = 64
) (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]  i_wr_addr,
    input  logic [LANES-1:0]          i_wr_lane,
    input  logic [LANE_W-1:0]         i_wr_data,
    input  logic                      i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]  i_rd_addr,
    output logic [LANES*LANE_W-1:0]   o_rd_data
);

    logic [LANES*LANE_W-1:0] mem [DEPTH];
    logic [LANES*LANE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LANES; l++) begin
            if (i_wr_en && i_wr_lane[l]) begin
                mem[i_wr_addr][l*LANE_W +: LANE_W] <= i_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/tlbt_lookup.sv */
// way compare, fault checks, refill slot choice and result formatting for one set
module tlbt_lookup (
    input  tlbt_pkg::t_item                                  i_item,
    input  logic [tlbt_pkg::WAYS*tlbt_pkg::ENTRY_W-1:0]      i_row,
    input  logic [tlbt_pkg::WAYS-1:0]                        i_row_vld,
    input  logic [tlbt_pkg::WAY_W-1:0]                       i_refill_cnt,
    output tlbt_pkg::t_result                                o_res
);

    logic [tlbt_pkg::ENTRY_W-1:0] w_ent   [tlbt_pkg::WAYS];
    logic [tlbt_pkg::WAYS-1:0]    w_match;
    logic [tlbt_pkg::WAYS-1:0]    w_pmatch;
    logic [31:0]                  w_look;
    logic [19:0]                  w_vpn;
    logic [tlbt_pkg::WAY_W-1:0]   w_hit_way;
    logic [tlbt_pkg::WAY_W-1:0]   w_pway;
    logic [tlbt_pkg::WAY_W-1:0]   w_inv_way;
    logic                         w_any_inv;
    logic [tlbt_pkg::WAY_W-1:0]   w_refill_way;
    logic [tlbt_pkg::ENTRY_W-1:0] w_hit_ent;
    logic [31:0]                  w_hit_flags;
    logic [tlbt_pkg::SET_W-1:0]   w_tset;
    logic [tlbt_pkg::SET_W-1:0]   w_pset;
    logic [tlbt_pkg::ENTRY_W-1:0] w_rd_ent;

    assign w_vpn  = i_item.virt_addr[31:12];
    assign w_look = {i_item.asid, w_vpn};
    assign w_tset = tlbt_pkg::set_of(w_vpn);
    assign w_pset = tlbt_pkg::set_of(i_item.entry_key[19:0]);

    always_comb begin
        for (int w = 0; w < tlbt_pkg::WAYS; w++) begin
            w_ent[w]    = i_row_vld[w] ? i_row[w*tlbt_pkg::ENTRY_W +: tlbt_pkg::ENTRY_W]
                                       : '0;
            w_match[w]  = w_ent[w][tlbt_pkg::FLAG_GLB]
                        ? (w_ent[w][63:32] == {12'd0, w_look[19:0] & tlbt_pkg::VPN_MASK})
                        : (w_ent[w][63:32] == w_look);
            w_pmatch[w] = (w_ent[w][63:32] == i_item.entry_key);
        end
    end

    // lowest matching way wins, highest invalid way is the refill choice
    always_comb begin
        w_hit_way = '0;
        w_pway    = '0;
        w_inv_way = '0;
        w_any_inv = 1'b0;
        for (int w = tlbt_pkg::WAYS - 1; w >= 0; w--) begin
            if (w_match[w]) begin
                w_hit_way = tlbt_pkg::WAY_W'(w);
            end
            if (w_pmatch[w]) begin
                w_pway = tlbt_pkg::WAY_W'(w);
            end
        end
        for (int w = 0; w < tlbt_pkg::WAYS; w++) begin
            if (!w_ent[w][tlbt_pkg::FLAG_VLD]) begin
                w_inv_way = tlbt_pkg::WAY_W'(w);
                w_any_inv = 1'b1;
            end
        end
    end

    assign w_refill_way = w_any_inv ? w_inv_way : i_refill_cnt;
    assign w_hit_ent    = w_ent[w_hit_way];
    assign w_hit_flags  = w_hit_ent[31:0];
    assign w_rd_ent     = w_ent[i_item.entry_index[tlbt_pkg::WAY_W-1:0]];

    always_comb begin
        o_res = '0;
        case (i_item.op)
            tlbt_pkg::OP_TRANSLATE: begin
                if (w_match == '0) begin
                    o_res.status     = tlbt_pkg::ST_MISS;
                    o_res.miss_key   = w_look;
                    o_res.dir_offset = {w_vpn[19:10], 2'b00};
                    o_res.slot_out   = {w_tset, w_refill_way};
                end else if (!w_hit_flags[tlbt_pkg::FLAG_VLD]
                             || (w_hit_flags[tlbt_pkg::FLAG_KERN] && i_item.user_mode)) begin
                    o_res.status = i_item.is_write ? tlbt_pkg::ST_FAULT_W
                                                   : tlbt_pkg::ST_FAULT_R;
                end else if (i_item.is_write && !w_hit_flags[tlbt_pkg::FLAG_WR]) begin
                    o_res.status = tlbt_pkg::ST_FAULT_W;
                end else begin
                    o_res.status    = tlbt_pkg::ST_OK;
                    o_res.phys_addr = {w_hit_flags[24:5], i_item.virt_addr[11:0]};
                    o_res.uncached  = w_hit_flags[tlbt_pkg::FLAG_UNC];
                end
            end
            tlbt_pkg::OP_WRITE: begin
                o_res = '0;
            end
            tlbt_pkg::OP_PROBE: begin
                if (w_pmatch != '0) begin
                    o_res.slot_out  = {w_pset, w_pway};
                    o_res.probe_hit = 1'b1;
                end
            end
            tlbt_pkg::OP_READ: begin
                o_res.read_hi = w_rd_ent[63:32];
                o_res.read_lo = w_rd_ent[31:0];
            end
            default: begin
                o_res = '0;
            end
        endcase
    end

endmodule

/* tb/sv/tb_set_assoc_tlb_translate_core.sv */
// testbench for the set-associative tlb core: directed and random words checked against a shadow tlb
module tb_set_assoc_tlb_translate_core;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_in_valid;
    logic                           o_in_stall;
    logic [1:0]                     i_op;
    logic [31:0]                    i_virt_addr;
    logic [11:0]                    i_asid;
    logic                           i_is_write;
    logic                           i_user_mode;
    logic [tlbt_pkg::SLOT_W-1:0]    i_entry_index;
    logic [31:0]                    i_entry_key;
    logic [31:0]                    i_entry_flags;
    logic                           o_out_valid;
    logic                           i_out_stall;
    logic [1:0]                     o_status;
    logic [31:0]                    o_phys_addr;
    logic                           o_uncached;
    logic [31:0]                    o_miss_key;
    logic [11:0]                    o_dir_offset;
    logic [tlbt_pkg::SLOT_W-1:0]    o_slot_out;
    logic                           o_probe_hit;
    logic [31:0]                    o_read_hi;
    logic [31:0]                    o_read_lo;

    set_assoc_tlb_translate_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_op          (i_op),
        .i_virt_addr   (i_virt_addr),
        .i_asid        (i_asid),
        .i_is_write    (i_is_write),
        .i_user_mode   (i_user_mode),
        .i_entry_index (i_entry_index),
        .i_entry_key   (i_entry_key),
        .i_entry_flags (i_entry_flags),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_phys_addr   (o_phys_addr),
        .o_uncached    (o_uncached),
        .o_miss_key    (o_miss_key),
        .o_dir_offset  (o_dir_offset),
        .o_slot_out    (o_slot_out),
        .o_probe_hit   (o_probe_hit),
        .o_read_hi     (o_read_hi),
        .o_read_lo     (o_read_lo)
    );

    logic [63:0]                  tlb_shadow [tlbt_pkg::ENTRIES] = '{default: '0};
    logic [tlbt_pkg::WAY_W-1:0]   refill_ctr = '0;
    tlbt_pkg::t_result            tlb_results_due [$];

    logic [19:0]       vpn_pool [12];
    logic [11:0]       asid_pool [3];

    int unsigned       in_idle_pct  = 0;
    int unsigned       out_idle_pct = 0;
    int unsigned       tlb_mismatches = 0;
    int unsigned       words_sent = 0;
    int unsigned       n_hits = 0;
    int unsigned       n_misses = 0;
    int unsigned       n_faults = 0;
    int unsigned       n_probe_hits = 0;
    int unsigned       n_entry_writes = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [tlbt_pkg::SET_W-1:0] tlb_set(input logic [19:0] vpn);
        return {vpn[19], vpn[2:0]};
    endfunction

    function automatic tlbt_pkg::t_result tlb_predict(input tlbt_pkg::t_item it);
        tlbt_pkg::t_result r;
        logic [19:0] vpn;
        logic [31:0] look;
        logic [31:0] mask;
        logic [63:0] e;
        logic        found;
        int          set;
        int          inval;
        int          way;
        r = '0;
        e = '0;
        case (it.op)
            tlbt_pkg::OP_TRANSLATE: begin
                vpn   = it.virt_addr[31:12];
                look  = {it.asid, vpn};
                set   = int'(tlb_set(vpn));
                found = 1'b0;
                inval = -1;
                for (int w = 0; w < tlbt_pkg::WAYS; w++) begin
                    e    = tlb_shadow[set * tlbt_pkg::WAYS + w];
                    mask = e[tlbt_pkg::FLAG_GLB] ? 32'h000F_FFFF : 32'hFFFF_FFFF;
                    if (e[63:32] == (look & mask)) begin
                        found = 1'b1;
                        break;
                    end
                    if (!e[tlbt_pkg::FLAG_VLD])
                        inval = w;
                end
                if (!found) begin
                    way          = (inval < 0) ? int'(refill_ctr) : inval;
                    r.status     = tlbt_pkg::ST_MISS;
                    r.miss_key   = look;
                    r.dir_offset = {vpn[19:10], 2'b00};
                    r.slot_out   = tlbt_pkg::SLOT_W'(set * tlbt_pkg::WAYS + way);
                end else if (!e[tlbt_pkg::FLAG_VLD]
                             || (e[tlbt_pkg::FLAG_KERN] && it.user_mode)) begin
                    r.status = it.is_write ? tlbt_pkg::ST_FAULT_W : tlbt_pkg::ST_FAULT_R;
                end else if (it.is_write && !e[tlbt_pkg::FLAG_WR]) begin
                    r.status = tlbt_pkg::ST_FAULT_W;
                end else begin
                    r.status    = tlbt_pkg::ST_OK;
                    r.phys_addr = {e[24:5], it.virt_addr[11:0]};
                    r.uncached  = e[tlbt_pkg::FLAG_UNC];
                end
            end
            tlbt_pkg::OP_WRITE: begin
                look = it.entry_flags[tlbt_pkg::FLAG_GLB] ? {12'h000, it.entry_key[19:0]}
                                                          : it.entry_key;
                tlb_shadow[it.entry_index] = {look, it.entry_flags};
                refill_ctr = refill_ctr + 1'b1;
            end
            tlbt_pkg::OP_PROBE: begin
                set = int'(tlb_set(it.entry_key[19:0]));
                for (int w = 0; w < tlbt_pkg::WAYS; w++) begin
                    if (tlb_shadow[set * tlbt_pkg::WAYS + w][63:32] == it.entry_key) begin
                        r.slot_out  = tlbt_pkg::SLOT_W'(set * tlbt_pkg::WAYS + w);
                        r.probe_hit = 1'b1;
                        break;
                    end
                end
            end
            default: begin
                r.read_hi = tlb_shadow[it.entry_index][63:32];
                r.read_lo = tlb_shadow[it.entry_index][31:0];
            end
        endcase
        return r;
    endfunction

    // drives one word, holds it through any stall and records what it should produce
    task automatic send_word(input tlbt_pkg::t_item it);
        tlbt_pkg::t_result r;
        int unsigned gap;
        @(negedge i_clk);
        if (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
            gap = $urandom_range(17, 1);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_op          <= it.op;
        i_virt_addr   <= it.virt_addr;
        i_asid        <= it.asid;
        i_is_write    <= it.is_write;
        i_user_mode   <= it.user_mode;
        i_entry_index <= it.entry_index;
        i_entry_key   <= it.entry_key;
        i_entry_flags <= it.entry_flags;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall)
                break;
        end
        r = tlb_predict(it);
        tlb_results_due.push_back(r);
        words_sent++;
        case (it.op)
            tlbt_pkg::OP_TRANSLATE: begin
                if (r.status == tlbt_pkg::ST_OK)
                    n_hits++;
                else if (r.status == tlbt_pkg::ST_MISS)
                    n_misses++;
                else
                    n_faults++;
            end
            tlbt_pkg::OP_WRITE: n_entry_writes++;
            tlbt_pkg::OP_PROBE: n_probe_hits += int'(r.probe_hit);
            default: ;
        endcase
    endtask

    function automatic tlbt_pkg::t_item noise_word();
        tlbt_pkg::t_item it;
        it.op          = tlbt_pkg::t_op'($urandom_range(3));
        it.virt_addr   = $urandom;
        it.asid        = 12'($urandom);
        it.is_write    = 1'($urandom);
        it.user_mode   = 1'($urandom);
        it.entry_index = tlbt_pkg::SLOT_W'($urandom);
        it.entry_key   = $urandom;
        it.entry_flags = $urandom;
        return it;
    endfunction

    task automatic do_translate(input logic [31:0] va, input logic [11:0] asid,
                                input logic wr, input logic user);
        tlbt_pkg::t_item it;
        it           = noise_word();
        it.op        = tlbt_pkg::OP_TRANSLATE;
        it.virt_addr = va;
        it.asid      = asid;
        it.is_write  = wr;
        it.user_mode = user;
        send_word(it);
    endtask

    task automatic do_write(input logic [tlbt_pkg::SLOT_W-1:0] idx, input logic [31:0] key,
                            input logic [31:0] flags);
        tlbt_pkg::t_item it;
        it             = noise_word();
        it.op          = tlbt_pkg::OP_WRITE;
        it.entry_index = idx;
        it.entry_key   = key;
        it.entry_flags = flags;
        send_word(it);
    endtask

    task automatic do_probe(input logic [31:0] key);
        tlbt_pkg::t_item it;
        it           = noise_word();
        it.op        = tlbt_pkg::OP_PROBE;
        it.entry_key = key;
        send_word(it);
    endtask

    task automatic do_read(input logic [tlbt_pkg::SLOT_W-1:0] idx);
        tlbt_pkg::t_item it;
        it             = noise_word();
        it.op          = tlbt_pkg::OP_READ;
        it.entry_index = idx;
        send_word(it);
    endtask

    // pages crowd into a few sets so that hits, full sets and refill choices all come up
    task automatic refresh_pools();
        logic [19:0] v;
        for (int i = 0; i < 12; i++) begin
            v      = 20'($urandom);
            v[1:0] = 2'($urandom_range(1));
            vpn_pool[i] = v;
        end
        for (int i = 0; i < 3; i++)
            asid_pool[i] = ($urandom_range(3) == 0) ? 12'h000 : 12'($urandom);
    endtask

    function automatic tlbt_pkg::t_item make_random_word();
        tlbt_pkg::t_item it;
        logic [19:0] vpn;
        logic [11:0] asid;
        int unsigned sel;
        it   = noise_word();
        vpn  = vpn_pool[$urandom_range(11)];
        asid = asid_pool[$urandom_range(2)];
        sel  = $urandom_range(99);
        if (sel < 45) begin
            it.op = tlbt_pkg::OP_TRANSLATE;
            if ($urandom_range(9) != 0) begin
                it.virt_addr = {vpn, 12'($urandom)};
                it.asid      = asid;
            end
        end else if (sel < 70) begin
            it.op = tlbt_pkg::OP_WRITE;
            if ($urandom_range(9) != 0)
                it.entry_index = {tlb_set(vpn), tlbt_pkg::WAY_W'($urandom)};
            if ($urandom_range(9) != 0)
                it.entry_key = {asid, vpn};
            it.entry_flags[tlbt_pkg::FLAG_VLD] = ($urandom_range(99) < 85);
            it.entry_flags[tlbt_pkg::FLAG_GLB] = ($urandom_range(99) < 20);
        end else if (sel < 85) begin
            it.op = tlbt_pkg::OP_PROBE;
            case ($urandom_range(2))
                0: it.entry_key = tlb_shadow[$urandom_range(tlbt_pkg::ENTRIES - 1)][63:32];
                1: it.entry_key = {asid, vpn};
                default: ;
            endcase
        end else begin
            it.op = tlbt_pkg::OP_READ;
        end
        return it;
    endfunction

    task automatic test_reset_state();
        do_read(6'd0);
        do_read(6'd63);
        do_translate(32'h0000_0000, 12'h000, 1'b0, 1'b0);
        do_translate(32'h0000_5123, 12'h001, 1'b1, 1'b1);
    endtask

    task automatic test_translate_hits();
        do_write(6'd9, {12'h005, 20'h00012}, (32'hABCDE << 5) | 32'h0B);
        do_translate(32'h0001_2345, 12'h005, 1'b0, 1'b1);
        do_translate(32'h0001_2FFF, 12'h005, 1'b1, 1'b0);
        do_write(6'd44, {12'hFFF, 20'h80003}, (32'h12345 << 5) | 32'h15);
        do_translate(32'h8000_3ABC, 12'h123, 1'b0, 1'b0);
        do_translate(32'h8000_3ABC, 12'h123, 1'b0, 1'b1);
    endtask

    task automatic test_faults();
        do_write(6'd8, {12'h005, 20'h0000A}, (32'h00777 << 5) | 32'h01);
        do_translate(32'h0000_A010, 12'h005, 1'b1, 1'b0);
        do_translate(32'h0000_A010, 12'h005, 1'b0, 1'b0);
        do_write(6'd10, {12'h005, 20'h0001A}, (32'h55555 << 5) | 32'h02);
        do_translate(32'h0001_A000, 12'h005, 1'b0, 1'b0);
    endtask

    task automatic test_probe();
        do_probe({12'h005, 20'h00012});
        do_probe(32'h0008_0003);
        do_probe({12'hFFF, 20'h80003});
    endtask

    task automatic test_refill();
        do_write(6'd11, {12'h005, 20'h0002A}, (32'h0F0F0 << 5) | 32'h03);
        do_write(6'd10, {12'h005, 20'h0001A}, (32'h55555 << 5) | 32'h03);
        do_translate(32'h0003_A000, 12'h005, 1'b0, 1'b0);
    endtask

    task automatic test_extremes();
        do_write(6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        do_read(6'd63);
        do_translate(32'hFFFF_FFFF, 12'hFFF, 1'b1, 1'b1);
        do_translate(32'hFFFF_FFFF, 12'hFFF, 1'b1, 1'b0);
    endtask

    task automatic test_random_mix(input int unsigned count);
        for (int unsigned i = 0; i < count; i++) begin
            if (i % 300 == 0)
                refresh_pools();
            if (i % 100 == 0) begin
                case ($urandom_range(3))
                    0: in_idle_pct = 0;
                    1: in_idle_pct = 5;
                    2: in_idle_pct = 20;
                    default: in_idle_pct = 50;
                endcase
                case ($urandom_range(3))
                    0: out_idle_pct = 0;
                    1: out_idle_pct = 5;
                    2: out_idle_pct = 20;
                    default: out_idle_pct = 50;
                endcase
            end
            send_word(make_random_word());
        end
    endtask

    task automatic test_random_steady(input int unsigned count);
        in_idle_pct  = 0;
        out_idle_pct = 0;
        refresh_pools();
        for (int unsigned i = 0; i < count; i++)
            send_word(make_random_word());
    endtask

    // result side backpressure
    initial begin
        int unsigned stall_len;
        i_out_stall = 1'b0;
        forever begin
            if (out_idle_pct != 0 && $urandom_range(99) < out_idle_pct) begin
                stall_len = $urandom_range(17, 1);
                @(negedge i_clk) i_out_stall <= 1'b1;
                repeat (stall_len - 1) @(negedge i_clk);
                @(negedge i_clk) i_out_stall <= 1'b0;
            end else begin
                @(negedge i_clk) i_out_stall <= 1'b0;
            end
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            tlb_mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        tlbt_pkg::t_result want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (tlb_results_due.size() == 0) begin
                $error("result word with nothing outstanding");
                tlb_mismatches++;
            end else begin
                want = tlb_results_due.pop_front();
                check_field("status", 32'(want.status), 32'(o_status));
                check_field("phys_addr", want.phys_addr, o_phys_addr);
                check_field("uncached", 32'(want.uncached), 32'(o_uncached));
                check_field("miss_key", want.miss_key, o_miss_key);
                check_field("dir_offset", 32'(want.dir_offset), 32'(o_dir_offset));
                check_field("slot_out", 32'(want.slot_out), 32'(o_slot_out));
                check_field("probe_hit", 32'(want.probe_hit), 32'(o_probe_hit));
                check_field("read_hi", want.read_hi, o_read_hi);
                check_field("read_lo", want.read_lo, o_read_lo);
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_op          = tlbt_pkg::OP_TRANSLATE;
        i_virt_addr   = '0;
        i_asid        = '0;
        i_is_write    = 1'b0;
        i_user_mode   = 1'b0;
        i_entry_index = '0;
        i_entry_key   = '0;
        i_entry_flags = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        test_reset_state();
        test_translate_hits();
        test_faults();
        test_probe();
        test_refill();
        test_extremes();
        test_random_mix(1200);
        test_random_steady(150);

        @(negedge i_clk) i_in_valid <= 1'b0;
        while (tlb_results_due.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("%0d words: %0d entry writes, %0d probe hits", words_sent, n_entry_writes,
                 n_probe_hits);
        $display("translations: %0d hits, %0d misses, %0d faults", n_hits, n_misses, n_faults);
        if (tlb_mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/tlbt_pkg.sv
rtl/tlbt_ram.sv
rtl/tlbt_lookup.sv
rtl/set_assoc_tlb_translate_core.sv
tb/sv/tb_set_assoc_tlb_translate_core.sv
